### rtl/rmth_pkg.sv
// rmth_pkg: shared types, constants and helpers for the running median unit
// no dependencies
package rmth_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int SAMPLE_W     = 32;
    localparam int MEDIAN_W     = 33;
    localparam int COUNT_OUT_W  = 11;

    // heap operation requests
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_REPLACE = 2'd1;

    typedef struct packed {
        logic              start;
        logic [1:0]        op;
        logic              is_max;
        logic [SAMPLE_W-1:0] value;
    } heap_cmd_t;

    // a goes ahead of b in the heap order
    function automatic logic goes_first(input logic signed [SAMPLE_W-1:0] a,
                                        input logic signed [SAMPLE_W-1:0] b,
                                        input logic is_max);
        logic r;
        begin
            r = is_max ? (a > b) : (a < b);
            return r;
        end
    endfunction

endpackage

### rtl/rmth_heap.sv
// rmth_heap: one binary heap held in a synchronous memory, with sift up and sift down
// depends on rmth_pkg
module rmth_heap #(
    parameter int DEPTH = rmth_pkg::CAPACITY_DEF / 2,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rmth_pkg::heap_cmd_t                cmd,
    input  logic [CNT_W-1:0]                   size,
    output logic                               busy,
    output logic signed [rmth_pkg::SAMPLE_W-1:0] top
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UP_RD = 3'd1;
    localparam logic [2:0] ST_UP_CK = 3'd2;
    localparam logic [2:0] ST_DN_RD = 3'd3;
    localparam logic [2:0] ST_DN_L  = 3'd4;
    localparam logic [2:0] ST_DN_CK = 3'd5;

    logic [rmth_pkg::SAMPLE_W-1:0] mem [DEPTH];

    logic [2:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                pos_reg, pos_next;
    logic [CNT_W-1:0]                size_reg, size_next;
    logic                            max_reg, max_next;
    logic signed [rmth_pkg::SAMPLE_W-1:0] val_reg, val_next;
    logic signed [rmth_pkg::SAMPLE_W-1:0] top_reg, top_next;
    logic signed [rmth_pkg::SAMPLE_W-1:0] lchild_reg, lchild_next;
    logic signed [rmth_pkg::SAMPLE_W-1:0] rd_data_reg;

    logic                   rd_en, wr_en;
    logic [IDX_W-1:0]       rd_addr, wr_addr;
    logic [rmth_pkg::SAMPLE_W-1:0] wr_data;

    logic [CNT_W-1:0]       parent;
    logic [CNT_W:0]         lidx, ridx;
    logic                   right_ok, take_right;
    logic signed [rmth_pkg::SAMPLE_W-1:0] best_val;
    logic [CNT_W-1:0]       best_idx;

    assign parent   = (pos_reg - CNT_W'(1)) >> 1;
    assign lidx     = {pos_reg, 1'b1};
    assign ridx     = lidx + (CNT_W+1)'(1);
    assign right_ok = ridx < {1'b0, size_reg};
    assign take_right = right_ok && rmth_pkg::goes_first(rd_data_reg, lchild_reg, max_reg);
    assign best_val = take_right ? rd_data_reg : lchild_reg;
    assign best_idx = take_right ? ridx[CNT_W-1:0] : lidx[CNT_W-1:0];

    // sift sequencer
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        size_next   = size_reg;
        max_next    = max_reg;
        val_next    = val_reg;
        top_next    = top_reg;
        lchild_next = lchild_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    max_next  = cmd.is_max;
                    val_next  = cmd.value;
                    size_next = size;
                    if (cmd.op == rmth_pkg::OP_INSERT)
                    begin
                        pos_next   = size;
                        state_next = ST_UP_RD;
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = ST_DN_RD;
                    end
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    top_next   = val_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent[IDX_W-1:0];
                    state_next = ST_UP_CK;
                end
            end
            ST_UP_CK:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[IDX_W-1:0];
                if (rmth_pkg::goes_first(val_reg, rd_data_reg, max_reg))
                begin
                    wr_data    = rd_data_reg;
                    pos_next   = parent;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DN_RD:
            begin
                if (lidx >= {1'b0, size_reg})
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[IDX_W-1:0];
                    if (pos_reg == '0)
                        top_next = val_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lidx[IDX_W-1:0];
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L:
            begin
                lchild_next = rd_data_reg;
                rd_en       = right_ok;
                rd_addr     = ridx[IDX_W-1:0];
                state_next  = ST_DN_CK;
            end
            ST_DN_CK:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[IDX_W-1:0];
                if (rmth_pkg::goes_first(best_val, val_reg, max_reg))
                begin
                    wr_data = best_val;
                    if (pos_reg == '0)
                        top_next = best_val;
                    pos_next   = best_idx;
                    state_next = ST_DN_RD;
                end
                else
                begin
                    if (pos_reg == '0)
                        top_next = val_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // heap storage, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        size_reg   <= size_next;
        max_reg    <= max_next;
        val_reg    <= val_next;
        top_reg    <= top_next;
        lchild_reg <= lchild_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign top  = top_reg;

`ifndef SYNTHESIS
    // no new command while a sift runs
    a_no_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.start) else $error("heap command while busy");
    // a check step of sift up either climbs on or ends the sift
    a_up_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_CK) |=> (state_reg == ST_UP_RD || state_reg == ST_IDLE))
        else $error("sift up left its loop");
    a_dn_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DN_L) |=> (state_reg == ST_DN_CK))
        else $error("sift down skipped its compare");
`endif

endmodule

### rtl/running_median_two_heaps_unit.sv
// running_median_two_heaps_unit: top level of the running median block
// depends on rmth_pkg and rmth_heap
//
// Usage: one signed 32-bit sample enters on the input channel (in_valid,
// in_stall, sample). For each sample one item leaves on the output channel
// (out_valid, out_stall, median_doubled, stored_count, dropped): twice the
// median of all samples held, the count held, and a flag that the store was
// full and the sample was discarded.
// Samples are held in two heaps, each in its own single-port-read memory.
// An item takes either a sift up on one heap, or a replace-top sift down on
// one heap and then a sift up on the other with the value it gave up. A sift
// down steps through a read, a left-child and a check state on each level, a
// sift up through a read and a check state, and the value is written into
// its place at the end. Each level waits on a synchronous memory read.
// One item is worked on at a time; in_stall is high while it runs, so the
// next item can first be taken in the cycle after the result is formed. A result waiting
// in the output register does not block the input; the next result waits.
// If the receiver stalls, the result holds steady on the output until taken.
// Reset clears the count and control; the heap memories need no clearing.
module running_median_two_heaps_unit #(
    parameter int CAPACITY = rmth_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rmth_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rmth_pkg::MEDIAN_W-1:0] median_doubled,
    output logic [rmth_pkg::COUNT_OUT_W-1:0]     stored_count,
    output logic                                 dropped
);

    localparam int LO_DEPTH = CAPACITY / 2;
    localparam int UP_DEPTH = (CAPACITY + 1) / 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LO_CW    = $clog2(LO_DEPTH + 1);
    localparam int UP_CW    = $clog2(UP_DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIRST = 3'd1;
    localparam logic [2:0] ST_WAIT1 = 3'd2;
    localparam logic [2:0] ST_WAIT2 = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic signed [rmth_pkg::SAMPLE_W-1:0] samp_reg, samp_next;
    logic              drop_reg, drop_next;
    logic              second_reg, second_next;
    logic              second_lo_reg, second_lo_next;
    logic signed [rmth_pkg::SAMPLE_W-1:0] cross_reg, cross_next;
    logic              ovalid_reg, ovalid_next;
    logic signed [rmth_pkg::MEDIAN_W-1:0] med_reg, med_next;
    logic [rmth_pkg::COUNT_OUT_W-1:0] cnt_out_reg, cnt_out_next;
    logic              dout_reg, dout_next;

    rmth_pkg::heap_cmd_t lo_cmd, up_cmd;
    logic              lo_busy, up_busy;
    logic signed [rmth_pkg::SAMPLE_W-1:0] lo_top, up_top;
    logic [LO_CW-1:0]  lo_size;
    logic [UP_CW-1:0]  up_size;
    logic [CNT_W-1:0]  nlo, nup;
    logic              accept;

    assign nlo     = count_reg >> 1;
    assign nup     = count_reg - nlo;
    assign lo_size = LO_CW'(nlo);
    assign up_size = UP_CW'(nup);
    assign accept  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // item sequencer: decide the side, run up to two sifts, build the result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        samp_next      = samp_reg;
        drop_next      = drop_reg;
        second_next    = second_reg;
        second_lo_next = second_lo_reg;
        cross_next     = cross_reg;
        ovalid_next    = ovalid_reg;
        med_next       = med_reg;
        cnt_out_next   = cnt_out_reg;
        dout_next      = dout_reg;
        lo_cmd         = '0;
        up_cmd         = '0;
        lo_cmd.is_max  = 1'b1;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    samp_next  = sample;
                    drop_next  = (count_reg >= CNT_W'(CAPACITY));
                    state_next = (count_reg >= CNT_W'(CAPACITY)) ? ST_DONE : ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                second_next = 1'b0;
                if (!count_reg[0])
                begin
                    if (nlo == '0 || samp_reg > lo_top)
                    begin
                        up_cmd.start = (nup < CNT_W'(UP_DEPTH));
                        up_cmd.op    = rmth_pkg::OP_INSERT;
                        up_cmd.value = samp_reg;
                    end
                    else
                    begin
                        lo_cmd.start   = 1'b1;
                        lo_cmd.op      = rmth_pkg::OP_REPLACE;
                        lo_cmd.value   = samp_reg;
                        cross_next     = lo_top;
                        second_next    = (nup < CNT_W'(UP_DEPTH));
                        second_lo_next = 1'b0;
                    end
                end
                else
                begin
                    if (nup != '0 && samp_reg >= up_top)
                    begin
                        up_cmd.start   = 1'b1;
                        up_cmd.op      = rmth_pkg::OP_REPLACE;
                        up_cmd.value   = samp_reg;
                        cross_next     = up_top;
                        second_next    = (nlo < CNT_W'(LO_DEPTH));
                        second_lo_next = 1'b1;
                    end
                    else
                    begin
                        lo_cmd.start = (nlo < CNT_W'(LO_DEPTH));
                        lo_cmd.op    = rmth_pkg::OP_INSERT;
                        lo_cmd.value = samp_reg;
                    end
                end
                state_next = ST_WAIT1;
            end
            ST_WAIT1:
            begin
                if (!lo_busy && !up_busy)
                begin
                    if (second_reg)
                    begin
                        if (second_lo_reg)
                        begin
                            lo_cmd.start = 1'b1;
                            lo_cmd.op    = rmth_pkg::OP_INSERT;
                            lo_cmd.value = cross_reg;
                        end
                        else
                        begin
                            up_cmd.start = 1'b1;
                            up_cmd.op    = rmth_pkg::OP_INSERT;
                            up_cmd.value = cross_reg;
                        end
                        state_next = ST_WAIT2;
                    end
                    else
                    begin
                        state_next = ST_WAIT2;
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_WAIT2:
            begin
                if (!lo_busy && !up_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // load the result once the output register is free
                if (!ovalid_reg || !out_stall)
                begin
                    if (!count_reg[0] && nlo != '0)
                        med_next = rmth_pkg::MEDIAN_W'(lo_top) + rmth_pkg::MEDIAN_W'(up_top);
                    else
                        med_next = {up_top, 1'b0};
                    cnt_out_next = rmth_pkg::COUNT_OUT_W'(count_reg);
                    dout_next    = drop_reg;
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rmth_heap #(
        .DEPTH (LO_DEPTH),
        .CNT_W (LO_CW)
    ) u_lower (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lo_cmd),
        .size  (lo_size),
        .busy  (lo_busy),
        .top   (lo_top)
    );

    rmth_heap #(
        .DEPTH (UP_DEPTH),
        .CNT_W (UP_CW)
    ) u_upper (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   ({up_cmd.start, up_cmd.op, 1'b0, up_cmd.value}),
        .size  (up_size),
        .busy  (up_busy),
        .top   (up_top)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg      <= samp_next;
        drop_reg      <= drop_next;
        second_reg    <= second_next;
        second_lo_reg <= second_lo_next;
        cross_reg     <= cross_next;
        med_reg       <= med_next;
        cnt_out_reg   <= cnt_out_next;
        dout_reg      <= dout_next;
    end

    assign out_valid      = ovalid_reg;
    assign median_doubled = med_reg;
    assign stored_count   = cnt_out_reg;
    assign dropped        = dout_reg;

`ifndef SYNTHESIS
    // count never passes the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY)) else $error("count beyond capacity");
    // a dropped item leaves the count alone
    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && drop_reg) |-> $stable(count_reg))
        else $error("dropped item changed count");
    // both heaps quiet when a result is formed
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!lo_busy && !up_busy))
        else $error("result formed while a sift runs");
    // the two heaps never sift at once
    a_one_sift: assert property (@(posedge clk) disable iff (!rst_n)
        !(lo_busy && up_busy)) else $error("both heaps busy");
`endif

endmodule
